FILE: design/vac_pkg.sv
// shared constants, command and status types for the voxel box collision step
// used by vac_ctrl, vac_dp and voxel_aabb_collision_step
package vac_pkg;

  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 24;
  localparam int VEL_W     = 16;
  localparam int DT_W      = 16;
  localparam int OCC_W     = 27;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int BLK_W     = 5;

  localparam int IN_TDATA_W  = 216;  // 211 payload bits padded to whole bytes
  localparam int OUT_TDATA_W = 120;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_DEPTH  = 2'd2;

  localparam logic [CFG_W-1:0] BOX_WIDTH_RST  = 12'd256;
  localparam logic [CFG_W-1:0] BOX_HEIGHT_RST = 12'd512;
  localparam logic [CFG_W-1:0] BOX_DEPTH_RST  = 12'd256;

  // axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // neighbour offset codes, in mask order 0, -1, +1
  localparam logic [1:0] OFF_ZERO = 2'd0;
  localparam logic [1:0] OFF_NEG  = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  localparam int ONE   = 1 << FRAC_BITS;
  localparam int HALF  = 1 << (FRAC_BITS - 1);
  localparam int GRAV  = ((981 << FRAC_BITS) + 50) / 100;

  // x / 200 as (x * RECIP_M) >> RECIP_SH, exact for x below 2^32 / 104
  localparam int          RECIP_SH = 32;
  localparam logic [24:0] RECIP_M  = 25'd21474837;

  localparam int ACC_W = 22;               // acceleration minus gravity
  localparam int PRD_W = ACC_W + DT_W + 1; // signed product with dt
  localparam int SUM_W = 40;               // headroom for sums before saturation
  localparam int DW    = 48;               // distance and penetration math
  localparam int C0_W  = POS_W - FRAC_BITS + 2;
  localparam int S_W   = 20;               // positive penetration, doubled
  localparam int T_W   = 24;               // s * 101 + 100
  localparam int PUSH_W = 18;

  typedef struct packed {
    logic             load;
    logic             vint;
    logic             move;
    logic             check;
    logic             apply;
    logic             fin;
    logic [1:0]       axis;
    logic [1:0]       off_x;
    logic [1:0]       off_y;
    logic [1:0]       off_z;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  typedef struct packed {
    logic occ_bit;
  } sts_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) return hi[POS_W-1:0];
    else if (v < lo) return lo[POS_W-1:0];
    else return v[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (VEL_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) return hi[VEL_W-1:0];
    else if (v < lo) return lo[VEL_W-1:0];
    else return v[VEL_W-1:0];
  endfunction

endpackage

FILE: design/vac_ctrl.sv
// sequencer for the collision step: integration, three axis passes, block scan
// depends on vac_pkg for command and status types
module vac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output vac_pkg::cmd_t cmd,
  input  vac_pkg::sts_t sts
);
  import vac_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VINT  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(OCC_W - 1);

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [1:0]       ix_r, ix_nxt, jy_r, jy_nxt, kz_r, kz_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       pass_axis;
  logic             scan_last;

  // pass order x, z, y
  always_comb begin
    case (cnt_r)
      2'd0:    pass_axis = AX_X;
      2'd1:    pass_axis = AX_Z;
      default: pass_axis = AX_Y;
    endcase
  end

  assign scan_last  = (blk_r == BLK_LAST);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    blk_nxt       = blk_r;
    ix_nxt        = ix_r;
    jy_nxt        = jy_r;
    kz_nxt        = kz_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    cmd       = '0;
    cmd.axis  = pass_axis;
    cmd.off_x = ix_r;
    cmd.off_y = jy_r;
    cmd.off_z = kz_r;
    cmd.blk   = blk_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 2'd0;
          state_nxt = S_VINT;
        end
      end
      S_VINT: begin
        cmd.vint = 1'b1;
        cmd.axis = cnt_r;
        if (cnt_r == 2'd2) begin
          cnt_nxt   = 2'd0;
          state_nxt = S_MOVE;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        blk_nxt   = '0;
        ix_nxt    = 2'd0;
        jy_nxt    = 2'd0;
        kz_nxt    = 2'd0;
        state_nxt = S_CHECK;
      end
      S_CHECK, S_APPLY: begin
        cmd.check = (state_r == S_CHECK);
        cmd.apply = (state_r == S_APPLY);
        if (state_r == S_CHECK && sts.occ_bit) begin
          state_nxt = S_APPLY;
        end else if (scan_last) begin
          if (cnt_r == 2'd2) begin
            state_nxt = S_FIN;
          end else begin
            cnt_nxt   = cnt_r + 2'd1;
            state_nxt = S_MOVE;
          end
        end else begin
          state_nxt = S_CHECK;
          blk_nxt   = blk_r + BLK_W'(1);
          // z innermost, then y, then x
          if (kz_r == 2'd2) begin
            kz_nxt = 2'd0;
            if (jy_r == 2'd2) begin
              jy_nxt = 2'd0;
              ix_nxt = ix_r + 2'd1;
            end else begin
              jy_nxt = jy_r + 2'd1;
            end
          end else begin
            kz_nxt = kz_r + 2'd1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      blk_r       <= '0;
      ix_r        <= 2'd0;
      jy_r        <= 2'd0;
      kz_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      blk_r       <= blk_nxt;
      ix_r        <= ix_nxt;
      jy_r        <= jy_nxt;
      kz_r        <= kz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/vac_dp.sv
// datapath: box registers, state of one item, shared dt multiplier, overlap check and push
// depends on vac_pkg; driven by vac_ctrl commands
module vac_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vac_pkg::cmd_t                         cmd,
  output vac_pkg::sts_t                         sts,
  input  logic                                  cfg_we,
  input  logic [vac_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vac_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic [vac_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic [vac_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tuser
);
  import vac_pkg::*;

  logic [CFG_W-1:0] size_r [3];

  logic signed [POS_W-1:0] p_r [3];
  logic signed [VEL_W-1:0] v_r [3];
  logic signed [VEL_W-1:0] a_r [3];
  logic signed [C0_W-1:0]  c0_r [3];
  logic [DT_W-1:0]         dt_r;
  logic [OCC_W-1:0]        occ_r;
  logic                    ground_r;
  logic                    hit_r;
  logic [S_W-1:0]          s_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;
  logic                    out_tuser_r;

  logic signed [POS_W-1:0] pin [3];
  logic signed [C0_W-1:0]  c0_in [3];
  logic signed [ACC_W-1:0] mul_a;
  logic signed [PRD_W-1:0] prod;
  logic signed [PRD_W-1:0] prod_rnd;
  logic signed [SUM_W-1:0] step_v;
  logic signed [VEL_W-1:0] vel_new;
  logic signed [POS_W-1:0] pos_new;
  logic signed [DW-1:0]    s_ax [3];
  logic                    hit_nxt;
  logic [T_W-1:0]          t_sum;
  logic [T_W+25-1:0]       t_prod;
  logic [PUSH_W-1:0]       push;
  logic signed [SUM_W-1:0] p_push;
  logic signed [POS_W-1:0] pos_pushed;
  logic signed [VEL_W-1:0] v_ax;

  assign sts.occ_bit = occ_r[cmd.blk];

  // input unpack and start-position rounding, half away from zero
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [POS_W+1:0] pe;
      logic signed [POS_W+1:0] rr;
      pin[j] = in_tdata[POS_W*j +: POS_W];
      pe = {{2{pin[j][POS_W-1]}}, pin[j]};
      if (!pe[POS_W+1]) begin
        rr = (pe + (POS_W+2)'(HALF)) >>> FRAC_BITS;
      end else begin
        rr = -((-pe + (POS_W+2)'(HALF)) >>> FRAC_BITS);
      end
      c0_in[j] = rr[C0_W-1:0];
    end
  end

  assign v_ax = v_r[cmd.axis];

  // shared dt multiplier, round to nearest with ties up
  always_comb begin
    if (cmd.vint) begin
      mul_a = ACC_W'(a_r[cmd.axis]) - ((cmd.axis == AX_Y) ? ACC_W'(GRAV) : ACC_W'(0));
    end else begin
      mul_a = ACC_W'(v_ax);
    end
    prod     = mul_a * $signed({1'b0, dt_r});
    prod_rnd = (prod + PRD_W'(1 << (DT_W - 1))) >>> DT_W;
    step_v   = SUM_W'(prod_rnd);
    vel_new  = sat_vel(SUM_W'(v_ax) + step_v);
    pos_new  = sat_pos(SUM_W'(p_r[cmd.axis]) + step_v);
  end

  // doubled penetration of the box against the current neighbour block
  always_comb begin
    logic [1:0] off [3];
    off[0] = cmd.off_x;
    off[1] = cmd.off_y;
    off[2] = cmd.off_z;
    for (int j = 0; j < 3; j++) begin
      logic signed [DW-1:0] cc;
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] ad;
      cc = DW'(c0_r[j]);
      case (off[j])
        OFF_NEG: cc = cc - DW'(1);
        OFF_POS: cc = cc + DW'(1);
        default: cc = cc;
      endcase
      d  = DW'(p_r[j]) - (cc <<< FRAC_BITS);
      ad = d[DW-1] ? -d : d;
      s_ax[j] = DW'({1'b0, size_r[j]}) + DW'(ONE) - (ad <<< 1);
    end
    hit_nxt = sts.occ_bit && (s_ax[0] > 0) && (s_ax[1] > 0) && (s_ax[2] > 0);
  end

  // push = floor((s * 101 + 100) / 200)
  always_comb begin
    t_sum = (T_W'(s_r) << 6) + (T_W'(s_r) << 5) + (T_W'(s_r) << 2) + T_W'(s_r)
            + T_W'(100);
    t_prod = (T_W+25)'(t_sum) * (T_W+25)'(RECIP_M);
    push   = t_prod[RECIP_SH +: PUSH_W];
    if (v_ax > 0) begin
      p_push = SUM_W'(p_r[cmd.axis]) - SUM_W'({1'b0, push});
    end else if (v_ax < 0) begin
      p_push = SUM_W'(p_r[cmd.axis]) + SUM_W'({1'b0, push});
    end else begin
      p_push = SUM_W'(p_r[cmd.axis]);
    end
    pos_pushed = sat_pos(p_push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0] <= BOX_WIDTH_RST;
      size_r[1] <= BOX_HEIGHT_RST;
      size_r[2] <= BOX_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_WIDTH:  size_r[0] <= cfg_wdata;
        REG_BOX_HEIGHT: size_r[1] <= cfg_wdata;
        REG_BOX_DEPTH:  size_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < 3; j++) begin
        p_r[j]  <= pin[j];
        v_r[j]  <= in_tdata[3*POS_W + VEL_W*j +: VEL_W];
        a_r[j]  <= in_tdata[3*POS_W + 3*VEL_W + VEL_W*j +: VEL_W];
        c0_r[j] <= c0_in[j];
      end
      dt_r     <= in_tdata[3*POS_W + 6*VEL_W +: DT_W];
      occ_r    <= in_tdata[3*POS_W + 6*VEL_W + DT_W +: OCC_W];
      ground_r <= 1'b0;
    end
    if (cmd.vint) begin
      v_r[cmd.axis] <= vel_new;
    end
    if (cmd.move) begin
      p_r[cmd.axis] <= pos_new;
    end
    if (cmd.check) begin
      hit_r <= hit_nxt;
      s_r   <= s_ax[cmd.axis][S_W-1:0];
    end
    if (cmd.apply && hit_r) begin
      p_r[cmd.axis] <= pos_pushed;
      v_r[cmd.axis] <= '0;
      if (cmd.axis == AX_Y) begin
        ground_r <= 1'b1;
      end
    end
    if (cmd.fin) begin
      out_tdata_r <= {v_r[2], v_r[1], v_r[0], p_r[2], p_r[1], p_r[0]};
      out_tuser_r <= ground_r;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

FILE: design/voxel_aabb_collision_step.sv
// top level of the box-versus-voxel collision step
// depends on vac_pkg, vac_ctrl and vac_dp
//
// usage: one input item describes a moving box and the occupancy of the 27
// unit blocks around its rounded start position; one result item comes back
// with the resolved position, velocity and the on_ground flag.
// channels: in_* stream (tvalid/tready/tdata), out_* stream with tuser as
// the on_ground flag, and a plain write port cfg_* for the box size.
// steps: velocity integration one axis at a time on the shared dt
// multiplier, then per axis pass one move step and a scan over the 27
// blocks, one block at a time through the single overlap-check unit,
// with an apply step after each occupied block.
// one item is worked at a time; in_tready is high only while idle.
// the result sits in an output register, so the next item is taken while
// a finished result still waits; a stalled receiver holds the block only
// when the next result is ready to be written.
// reset (rst_n low, synchronous) drops out_tvalid, returns to idle and
// restores box width 256, height 512 and depth 256 (Q.8 blocks).
// configuration is to be written by the user only while the block is idle; the block itself does not enforce it.
module voxel_aabb_collision_step (
  input  logic                                clk,
  input  logic                                rst_n,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z,
  // time_step, occupancy, zero padding (lowest bit first)
  input  logic [vac_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  output logic [vac_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // on_ground
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [vac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vac_pkg::CFG_W-1:0]           cfg_wdata
);
  import vac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: integration, axis passes x then z then y, result handoff
  vac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // item registers, multiplier, overlap check and output register
  vac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

FILE: tb/voxel_aabb_collision_step_test.sv
// self-checking bench for voxel_aabb_collision_step: drives box items on the in_ stream,
// predicts each result in place and compares it with the out_ stream
// depends on vac_pkg and the voxel_aabb_collision_step rtl
`timescale 1ns / 1ps

module voxel_aabb_collision_step_test;
  import vac_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] pos [3];
    logic signed [VEL_W-1:0] vel [3];
    logic signed [VEL_W-1:0] acc [3];
    logic [DT_W-1:0]         dt;
    logic [OCC_W-1:0]        occ;
  } box_item_t;

  typedef struct {
    logic signed [POS_W-1:0] pos [3];
    logic signed [VEL_W-1:0] vel [3];
    logic                    ground;
  } box_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  voxel_aabb_collision_step dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // box size as the predictor sees it, in x, y, z order
  longint box_size [3] = '{256, 512, 256};

  logic [IN_TDATA_W-1:0] pending_items [$];
  box_result_t expected_results [$];
  int errors = 0;
  int sent_count = 0;
  int got_count = 0;
  int ground_count = 0;
  bit idle_on = 1'b1;       // random gaps on both sides
  int hold_cycles = 0;      // receiver long hold-off, counted down in the monitor

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint scale_dt(longint v, longint dt);
    return shr_floor(v * dt + (longint'(1) <<< (DT_W - 1)), DT_W);
  endfunction

  function automatic longint round_block(longint p);
    if (p >= 0) return shr_floor(p + HALF, FRAC_BITS);
    return -shr_floor(-p + HALF, FRAC_BITS);
  endfunction

  // one step of integration and the three axis passes (x, z, y)
  function automatic box_result_t resolve_box(box_item_t it);
    box_result_t r;
    longint p [3], v [3], c0 [3], s [3], offs [3];
    longint c, push, d;
    int ax, sg;
    int axis_order [3];
    offs = '{0, -1, 1};
    axis_order = '{0, 2, 1};
    r.ground = 1'b0;
    for (int j = 0; j < 3; j++) begin
      p[j] = it.pos[j];
      v[j] = clamp(longint'(it.vel[j]) +
                   scale_dt(longint'(it.acc[j]) - (j == 1 ? GRAV : 0), it.dt), VEL_W);
      c0[j] = round_block(p[j]);
    end
    for (int n = 0; n < 3; n++) begin
      ax = axis_order[n];
      p[ax] = clamp(p[ax] + scale_dt(v[ax], it.dt), POS_W);
      for (int b = 0; b < 27; b++) begin
        if (it.occ[b]) begin
          for (int j = 0; j < 3; j++) begin
            c = (c0[j] + offs[j == 0 ? b / 9 : (j == 1 ? (b / 3) % 3 : b % 3)]) * ONE;
            d = p[j] - c;
            if (d < 0) d = -d;
            s[j] = box_size[j] + ONE - 2 * d;
          end
          if (s[0] > 0 && s[1] > 0 && s[2] > 0) begin
            push = (s[ax] * 101 + 100) / 200;
            sg = (v[ax] > 0) ? 1 : ((v[ax] < 0) ? -1 : 0);
            p[ax] = clamp(p[ax] - push * sg, POS_W);
            v[ax] = 0;
            if (ax == 1) r.ground = 1'b1;
          end
        end
      end
    end
    for (int j = 0; j < 3; j++) begin
      r.pos[j] = p[j][POS_W-1:0];
      r.vel[j] = v[j][VEL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_box(box_item_t it);
    return IN_TDATA_W'({it.occ, it.dt, it.acc[2], it.acc[1], it.acc[0],
                        it.vel[2], it.vel[1], it.vel[0], it.pos[2], it.pos[1], it.pos[0]});
  endfunction

  function automatic box_item_t unpack_box(logic [IN_TDATA_W-1:0] d);
    box_item_t it;
    for (int j = 0; j < 3; j++) begin
      it.pos[j] = d[j*POS_W +: POS_W];
      it.vel[j] = d[3*POS_W + j*VEL_W +: VEL_W];
      it.acc[j] = d[3*POS_W + 3*VEL_W + j*VEL_W +: VEL_W];
    end
    it.dt = d[3*POS_W + 6*VEL_W +: DT_W];
    it.occ = d[3*POS_W + 6*VEL_W + DT_W +: OCC_W];
    return it;
  endfunction

  // mostly moderate values near block boundaries so collisions happen, some full range
  function automatic box_item_t random_box();
    box_item_t it;
    int mode;
    mode = $urandom_range(0, 9);
    for (int j = 0; j < 3; j++) begin
      if (mode == 0) begin
        it.pos[j] = $urandom;
        it.vel[j] = $urandom;
        it.acc[j] = $urandom;
      end else begin
        it.pos[j] = $signed($urandom_range(0, 4096)) - 2048;
        if ($urandom_range(0, 19) == 0)
          it.pos[j] = $urandom_range(0, 1) ? 24'sh7FFF00 + $urandom_range(0, 255)
                                           : -24'sh800000 + $urandom_range(0, 255);
        it.vel[j] = $signed($urandom_range(0, 8192)) - 4096;
        it.acc[j] = $signed($urandom_range(0, 8192)) - 4096;
        if ($urandom_range(0, 9) == 0) it.vel[j] = 0;
      end
    end
    it.dt = (mode < 2) ? 16'($urandom) : 16'($urandom_range(0, 8000));
    it.occ = $urandom;
    if (mode == 3) it.occ = '0;
    if (mode == 4) it.occ = '1;
    return it;
  endfunction

  function automatic box_item_t edge_box(int k);
    box_item_t it;
    for (int j = 0; j < 3; j++) begin
      it.pos[j] = 0;
      it.vel[j] = 0;
      it.acc[j] = 0;
    end
    it.dt = 16'd1000;
    it.occ = '0;
    case (k)
      0: ;
      1: it.occ = '1;
      2: begin  // resting on the block below, zero velocity at the hit
        it.pos[1] = 24'sd200; it.occ = 27'(1) << 3; it.dt = 0;
      end
      3: begin  // falling onto the floor, pushed back
        it.pos[1] = 24'sd300; it.vel[1] = -16'sd2000; it.occ = 27'(1) << 3;
      end
      4: begin
        for (int j = 0; j < 3; j++) begin
          it.pos[j] = 24'sh7FFFFF; it.vel[j] = 16'sh7FFF; it.acc[j] = 16'sh7FFF;
        end
        it.dt = 16'hFFFF; it.occ = '1;
      end
      5: begin
        for (int j = 0; j < 3; j++) begin
          it.pos[j] = -24'sh800000; it.vel[j] = -16'sh8000; it.acc[j] = -16'sh8000;
        end
        it.dt = 16'hFFFF; it.occ = '1;
      end
      6: begin  // sideways into the +x wall
        it.vel[0] = 16'sd4000; it.pos[0] = 24'sd100; it.occ = 27'(1) << 18;
      end
      7: begin  // moving in -z inside the centre x layer of blocks, several hits on one axis
        it.vel[2] = -16'sd4000; it.occ = 27'h1FF;
      end
      8: begin  // rounding: half values on each side of zero
        it.pos[0] = 24'sd128; it.pos[1] = -24'sd128; it.pos[2] = -24'sd127; it.occ = '1;
      end
      9: begin
        it.pos[0] = 24'sh7FFFFF; it.vel[0] = 16'sh7FFF; it.dt = 16'hFFFF;
      end
      10: begin
        it.pos[2] = -24'sh800000; it.vel[2] = -16'sh8000; it.dt = 16'hFFFF;
      end
      default: it = random_box();
    endcase
    return it;
  endfunction

  // driver: nonblocking at the rising edge, random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_items.pop_front());
        expected_results.insert(expected_results.size(), resolve_box(unpack_box(in_tdata)));
        sent_count <= sent_count + 1;
      end
      if (pending_items.size() > (in_tvalid && in_tready ? 0 : 0) &&
          !(idle_on && $urandom_range(0, 99) < 22)) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_items[0];
      end else if (!(in_tvalid && !in_tready)) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    box_result_t want;
    logic signed [POS_W-1:0] gp;
    logic signed [VEL_W-1:0] gv;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_count <= got_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.ground) ground_count <= ground_count + 1;
          for (int j = 0; j < 3; j++) begin
            gp = out_tdata[j*POS_W +: POS_W];
            gv = out_tdata[3*POS_W + j*VEL_W +: VEL_W];
            if (gp !== want.pos[j]) begin
              $error("new_pos[%0d]: expected %0d, got %0d", j, want.pos[j], gp);
              errors = errors + 1;
            end
            if (gv !== want.vel[j]) begin
              $error("new_vel[%0d]: expected %0d, got %0d", j, want.vel[j], gv);
              errors = errors + 1;
            end
          end
          if (out_tuser !== want.ground) begin
            $error("on_ground: expected %0b, got %0b", want.ground, out_tuser);
            errors = errors + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(0, 99) < 22);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    box_size[idx] = val;
  endtask

  // wait until every expected result is back, then a settling pause
  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] sizes [4][3];
    sizes = '{'{12'd256, 12'd512, 12'd256}, '{12'd0, 12'd0, 12'd0},
              '{12'd4095, 12'd4095, 12'd4095}, '{12'd100, 12'd900, 12'd3000}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed items at reset size
    for (int k = 0; k < 11; k++)
      pending_items.insert(pending_items.size(), pack_box(edge_box(k)));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase < 4) begin
        write_reg(REG_BOX_WIDTH, sizes[phase][0]);
        write_reg(REG_BOX_HEIGHT, sizes[phase][1]);
        write_reg(REG_BOX_DEPTH, sizes[phase][2]);
      end else begin
        write_reg(REG_BOX_WIDTH, 12'($urandom));
        write_reg(REG_BOX_HEIGHT, 12'($urandom));
        write_reg(REG_BOX_DEPTH, 12'($urandom));
      end
      idle_on = (phase != 1);
      // a long receiver hold-off while items keep coming
      if (phase == 2) hold_cycles = 1500;
      for (int i = 0; i < 350; i++)
        pending_items.insert(pending_items.size(), pack_box(random_box()));
      if (phase < 4)
        pending_items.insert(pending_items.size(), pack_box(edge_box(phase + 2)));
      drain();
    end

    $display("ran %0d box items through five box sizes, %0d results, %0d on ground",
             sent_count, got_count, ground_count);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
